FILE: hw/rtl/lpp_pkg.sv
// Shared types, constants and a helper function of the lidar point projection block.
`default_nettype none

package lpp_pkg;

   // Register map of the configuration port.
   localparam int NUM_REGS = 8;
   localparam logic [7:0] REG_ROT0 = 8'd0;
   localparam logic [7:0] REG_ROT1 = 8'd1;
   localparam logic [7:0] REG_ROT2 = 8'd2;
   localparam logic [7:0] REG_TRANS = 8'd3;
   localparam logic [7:0] REG_INTR0 = 8'd4;
   localparam logic [7:0] REG_INTR1 = 8'd5;
   localparam logic [7:0] REG_INTR2 = 8'd6;
   localparam logic [7:0] REG_WINDOW = 8'd7;

   // Result status codes.
   typedef enum logic [1:0] {
      OUT_VALID  = 2'd0,
      OUT_BEHIND = 2'd1,
      OUT_ZERO   = 2'd2,
      OUT_WINDOW = 2'd3
   } outcome_type;

   // Fixed-point layout of the projection arithmetic.
   localparam int ROT_SHIFT = 15;   // translation to rotation fraction alignment
   localparam int DROP_BITS = 15;   // fraction bits dropped after the rigid move
   localparam int INT_BITS = 17;    // quotient integer bits before saturation
   localparam int FRAC_BITS = 16;   // quotient fraction bits
   localparam int QUOT_W = INT_BITS + FRAC_BITS;
   localparam logic [QUOT_W-1:0] QUOT_SAT = {QUOT_W{1'b1}};
   localparam int SUM_W = QUOT_W + 2;
   localparam int OFF_COL = 1119368;
   localparam int OFF_ROW = 872297;

   // Scaling by 1000/683 with a bias that keeps the dividend positive.
   localparam logic [10:0] SCALE_NUM = 11'd1000;
   localparam logic [9:0] SCALE_DEN = 10'd683;
   localparam int BIAS_SHIFT = 34;
   localparam int U_W = 44;
   localparam int SC_W = 46;
   localparam int DIGIT_W = 4;
   localparam int N_DIGITS = U_W / DIGIT_W;
   localparam int COL_W = U_W + 1;

   // One radix-16 digit of long division by the scale denominator.
   // Returns the quotient digit above the new remainder.
   function automatic logic [DIGIT_W+9:0] den_digit(input logic [9:0] rem,
                                                   input logic [DIGIT_W-1:0] nib);
      logic [10:0] r;
      logic [DIGIT_W-1:0] q;
      r = {1'b0, rem};
      q = '0;
      for (int b = DIGIT_W - 1; b >= 0; b--) begin
         r = {r[9:0], nib[b]};
         if (r >= {1'b0, SCALE_DEN}) begin
            r = r - {1'b0, SCALE_DEN};
            q[b] = 1'b1;
         end
      end
      return {q, r[9:0]};
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lidar_point_to_pixel_projection.sv
// Top level of the lidar point to pixel projection pipeline.
//
// The block projects lidar points into camera pixel space: a rigid move by the
// rotation and translation registers, the intrinsic matrix, a division by
// depth, the fixed offsets and the 1/0.683 scale, and finally an inclusive
// window test. A new point can be taken on every cycle while the output skid
// slot is free. Each result passes four multiply and sum stages, one setup
// stage and 33 one-bit stages of the depth divider, two stages for offset and
// scale, eleven radix-16 stages of the constant divider and the output
// register. A two-entry output buffer lets the pipeline keep taking points
// while one result waits. Points with a negative forward coordinate report
// "behind camera", a zero depth reports "zero depth" and pixels outside the
// window report "outside window", all with pixel (0,0). The user is to write
// configuration only while no point is in flight; the block does not enforce it.
`default_nettype none

module lidar_point_to_pixel_projection #(
   parameter int COEF_WIDTH = 21,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   // Point input; req_tdata fields from bit 0: coord_right, coord_forward, coord_up.
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // Pixel output; rsp_tdata fields from bit 0: pixel_col, pixel_row.
   output logic        rsp_tvalid,
   input  wire logic   rsp_tready,
   output logic [31:0] rsp_tdata,
   // rsp_tuser fields from bit 0: outcome.
   output logic [1:0]  rsp_tuser,
   // Configuration writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int CW = COEF_WIDTH;
   localparam int PW = COORD_WIDTH;
   localparam int P1_W = CW + PW;
   localparam int A1_W = P1_W + 2;
   localparam int PT_W = A1_W - lpp_pkg::DROP_BITS;
   localparam int P2_W = CW + PT_W;
   localparam int A2_W = P2_W + 2;
   localparam int M_W = A2_W;
   localparam int R_W = M_W + lpp_pkg::INT_BITS;
   localparam int QW = lpp_pkg::QUOT_W;
   localparam int ND = lpp_pkg::N_DIGITS;
   localparam int UW = lpp_pkg::U_W;
   localparam int DW = lpp_pkg::DIGIT_W;

   // Configuration registers.
   logic [63:0] csr_ff [lpp_pkg::NUM_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lpp_pkg::NUM_REGS; i++) csr_ff[i] <= '0;
      end else if (csr_valid && csr_index < 8'(lpp_pkg::NUM_REGS)) begin
         csr_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // Coefficients unpacked from the registers.
   logic signed [CW-1:0] rot [3][3];
   logic signed [CW-1:0] kin [3][3];
   logic signed [CW-1:0] trn [3];
   logic [15:0] xmin, xmax, ymin, ymax;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rot[i][j] = csr_ff[lpp_pkg::REG_ROT0[2:0] + 3'(i)][j*CW +: CW];
            kin[i][j] = csr_ff[lpp_pkg::REG_INTR0[2:0] + 3'(i)][j*CW +: CW];
         end
         trn[i] = csr_ff[lpp_pkg::REG_TRANS[2:0]][i*CW +: CW];
      end
      xmin = csr_ff[lpp_pkg::REG_WINDOW[2:0]][15:0];
      xmax = csr_ff[lpp_pkg::REG_WINDOW[2:0]][31:16];
      ymin = csr_ff[lpp_pkg::REG_WINDOW[2:0]][47:32];
      ymax = csr_ff[lpp_pkg::REG_WINDOW[2:0]][63:48];
   end

   // The whole pipeline advances while the output skid slot is free.
   logic ce;
   logic skid_valid_ff;

   assign ce = !skid_valid_ff;
   assign req_tready = ce;

   // Stage 1: rotation products.
   logic signed [PW-1:0] pnt [3];
   logic signed [P1_W-1:0] prod1_in [3][3];
   logic signed [P1_W-1:0] prod1_ff [3][3];
   logic v1_ff, behind1_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) pnt[j] = req_tdata[j*PW +: PW];
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) prod1_in[i][j] = rot[i][j] * pnt[j];
   end

   // Stage 2: add translation and drop to camera-frame fraction.
   logic signed [A1_W-1:0] acc1_in [3];
   logic signed [PT_W-1:0] pt2_ff [3];
   logic v2_ff, behind2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++)
         acc1_in[i] = (A1_W'(trn[i]) <<< lpp_pkg::ROT_SHIFT) + A1_W'(prod1_ff[i][0])
                      + A1_W'(prod1_ff[i][1]) + A1_W'(prod1_ff[i][2]);
   end

   // Stage 3: intrinsic products.
   logic signed [P2_W-1:0] prod3_in [3][3];
   logic signed [P2_W-1:0] prod3_ff [3][3];
   logic v3_ff, behind3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) prod3_in[i][j] = kin[i][j] * pt2_ff[j];
   end

   // Stage 4: homogeneous image coordinates.
   logic signed [A2_W-1:0] a4_in [3];
   logic signed [A2_W-1:0] a4_ff [3];
   logic v4_ff, behind4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++)
         a4_in[i] = A2_W'(prod3_ff[i][0]) + A2_W'(prod3_ff[i][1]) + A2_W'(prod3_ff[i][2]);
   end

   // Depth divider: entry 0 is the setup stage, each later entry retires one
   // quotient bit. Lane 0 is the column, lane 1 the row.
   logic [R_W-1:0] div_rem_in [QW+1][2];
   logic [R_W-1:0] div_rem_ff [QW+1][2];
   logic [QW-1:0]  div_quo_in [QW+1][2];
   logic [QW-1:0]  div_quo_ff [QW+1][2];
   logic [M_W-1:0] div_den_in [QW+1];
   logic [M_W-1:0] div_den_ff [QW+1];
   logic           div_neg_in [QW+1][2];
   logic           div_neg_ff [QW+1][2];
   logic           div_sat_in [QW+1][2];
   logic           div_sat_ff [QW+1][2];
   lpp_pkg::outcome_type div_out_in [QW+1];
   lpp_pkg::outcome_type div_out_ff [QW+1];
   logic           div_v_ff [QW+1];

   always_comb begin
      logic [M_W-1:0] num;
      logic [R_W:0]   trial;
      logic [R_W-1:0] kept;
      // Setup: magnitudes, signs and the saturation test.
      div_den_in[0] = a4_ff[2][A2_W-1] ? M_W'(-a4_ff[2]) : M_W'(a4_ff[2]);
      for (int c = 0; c < 2; c++) begin
         num = a4_ff[c][A2_W-1] ? M_W'(-a4_ff[c]) : M_W'(a4_ff[c]);
         div_rem_in[0][c] = R_W'(num);
         div_quo_in[0][c] = '0;
         div_neg_in[0][c] = a4_ff[c][A2_W-1] ^ a4_ff[2][A2_W-1];
         div_sat_in[0][c] = R_W'(num) >= {div_den_in[0], {lpp_pkg::INT_BITS{1'b0}}};
      end
      if (behind4_ff) div_out_in[0] = lpp_pkg::OUT_BEHIND;
      else if (a4_ff[2] == '0) div_out_in[0] = lpp_pkg::OUT_ZERO;
      else div_out_in[0] = lpp_pkg::OUT_VALID;
      // One restoring step per stage against the denominator shifted left by the
      // quotient fraction bits.
      for (int k = 1; k <= QW; k++) begin
         div_den_in[k] = div_den_ff[k-1];
         div_out_in[k] = div_out_ff[k-1];
         for (int c = 0; c < 2; c++) begin
            trial = {1'b0, div_rem_ff[k-1][c]}
                    - (R_W+1)'({div_den_ff[k-1], {lpp_pkg::FRAC_BITS{1'b0}}});
            kept = trial[R_W] ? div_rem_ff[k-1][c] : trial[R_W-1:0];
            div_rem_in[k][c] = {kept[R_W-2:0], 1'b0};
            div_quo_in[k][c] = {div_quo_ff[k-1][c][QW-2:0], !trial[R_W]};
            div_neg_in[k][c] = div_neg_ff[k-1][c];
            div_sat_in[k][c] = div_sat_ff[k-1][c];
         end
      end
   end

   // Offset stage: apply sign and saturation, add the fixed pixel offsets.
   logic [QW-1:0] mag_q [2];
   logic signed [QW:0] quo_s [2];
   logic signed [lpp_pkg::SUM_W-1:0] sum_in [2];
   logic signed [lpp_pkg::SUM_W-1:0] sum_ff [2];
   lpp_pkg::outcome_type sum_out_ff;
   logic sum_v_ff;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         mag_q[c] = div_sat_ff[QW][c] ? lpp_pkg::QUOT_SAT : div_quo_ff[QW][c];
         quo_s[c] = div_neg_ff[QW][c] ? -$signed({1'b0, mag_q[c]}) : $signed({1'b0, mag_q[c]});
      end
      sum_in[0] = lpp_pkg::SUM_W'(quo_s[0]) + lpp_pkg::SUM_W'(lpp_pkg::OFF_COL);
      sum_in[1] = lpp_pkg::SUM_W'(quo_s[1]) + lpp_pkg::SUM_W'(lpp_pkg::OFF_ROW);
   end

   // Constant divider: entry 0 holds the scaled, biased dividend; each later
   // entry retires one radix-16 digit.
   logic [lpp_pkg::SC_W-1:0] scaled [2];
   logic [UW-1:0] cd_u_in [ND+1][2];
   logic [UW-1:0] cd_u_ff [ND+1][2];
   logic [UW-1:0] cd_q_in [ND+1][2];
   logic [UW-1:0] cd_q_ff [ND+1][2];
   logic [9:0]    cd_r_in [ND+1][2];
   logic [9:0]    cd_r_ff [ND+1][2];
   lpp_pkg::outcome_type cd_out_in [ND+1];
   lpp_pkg::outcome_type cd_out_ff [ND+1];
   logic          cd_v_ff [ND+1];

   always_comb begin
      logic [DW+9:0] dig;
      for (int c = 0; c < 2; c++) begin
         scaled[c] = lpp_pkg::SC_W'(sum_ff[c]) * lpp_pkg::SC_W'(lpp_pkg::SCALE_NUM)
                     + (lpp_pkg::SC_W'(lpp_pkg::SCALE_DEN) << lpp_pkg::BIAS_SHIFT);
         cd_u_in[0][c] = scaled[c][UW-1:0];
         cd_q_in[0][c] = '0;
         cd_r_in[0][c] = '0;
      end
      cd_out_in[0] = sum_out_ff;
      for (int k = 1; k <= ND; k++) begin
         cd_out_in[k] = cd_out_ff[k-1];
         for (int c = 0; c < 2; c++) begin
            dig = lpp_pkg::den_digit(cd_r_ff[k-1][c], cd_u_ff[k-1][c][UW-1 -: DW]);
            cd_r_in[k][c] = dig[9:0];
            cd_q_in[k][c] = {cd_q_ff[k-1][c][UW-DW-1:0], dig[DW+9:10]};
            cd_u_in[k][c] = {cd_u_ff[k-1][c][UW-DW-1:0], {DW{1'b0}}};
         end
      end
   end

   // Window test on the Q.16 pixel after removing the bias.
   localparam int CLW = lpp_pkg::COL_W;
   logic signed [CLW-1:0] pix [2];
   logic outside;
   lpp_pkg::outcome_type fin_out;
   logic [31:0] fin_data;

   always_comb begin
      for (int c = 0; c < 2; c++)
         pix[c] = $signed({1'b0, cd_q_ff[ND][c]}) - (CLW'(1) <<< lpp_pkg::BIAS_SHIFT);
      outside = (pix[0] < $signed(CLW'({xmin, 16'h0000})))
             || (pix[0] > $signed(CLW'({xmax, 16'h0000})))
             || (pix[1] < $signed(CLW'({ymin, 16'h0000})))
             || (pix[1] > $signed(CLW'({ymax, 16'h0000})));
      fin_out = cd_out_ff[ND];
      if (fin_out == lpp_pkg::OUT_VALID && outside) fin_out = lpp_pkg::OUT_WINDOW;
      if (fin_out == lpp_pkg::OUT_VALID) fin_data = {pix[1][31:16], pix[0][31:16]};
      else fin_data = '0;
   end

   // Pipeline registers, all moved together.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         sum_v_ff <= 1'b0;
         for (int k = 0; k <= QW; k++) div_v_ff[k] <= 1'b0;
         for (int k = 0; k <= ND; k++) cd_v_ff[k] <= 1'b0;
      end else if (ce) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         div_v_ff[0] <= v4_ff;
         for (int k = 1; k <= QW; k++) div_v_ff[k] <= div_v_ff[k-1];
         sum_v_ff <= div_v_ff[QW];
         cd_v_ff[0] <= sum_v_ff;
         for (int k = 1; k <= ND; k++) cd_v_ff[k] <= cd_v_ff[k-1];
      end
      if (ce) begin
         prod1_ff <= prod1_in;
         behind1_ff <= pnt[1][PW-1];
         for (int i = 0; i < 3; i++) pt2_ff[i] <= acc1_in[i][A1_W-1:lpp_pkg::DROP_BITS];
         behind2_ff <= behind1_ff;
         prod3_ff <= prod3_in;
         behind3_ff <= behind2_ff;
         a4_ff <= a4_in;
         behind4_ff <= behind3_ff;
         div_rem_ff <= div_rem_in;
         div_quo_ff <= div_quo_in;
         div_den_ff <= div_den_in;
         div_neg_ff <= div_neg_in;
         div_sat_ff <= div_sat_in;
         div_out_ff <= div_out_in;
         sum_ff <= sum_in;
         sum_out_ff <= div_out_ff[QW];
         cd_u_ff <= cd_u_in;
         cd_q_ff <= cd_q_in;
         cd_r_ff <= cd_r_in;
         cd_out_ff <= cd_out_in;
      end
   end

   // Output register with one skid slot behind it.
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, skid_data_ff;
   logic [1:0]  rsp_user_ff, skid_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= cd_v_ff[ND];
         end
      end else if (ce && cd_v_ff[ND]) begin
         skid_valid_ff <= 1'b1;
      end
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
            rsp_user_ff <= skid_user_ff;
         end else begin
            rsp_data_ff <= fin_data;
            rsp_user_ff <= fin_out;
         end
      end else if (ce) begin
         skid_data_ff <= fin_data;
         skid_user_ff <= fin_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

`default_nettype wire
